// File: hdl/assert_macros.svh
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// File: hdl/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types, constants and command structs of the table interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;
   localparam int TABLE_DEPTH_DEF = 256;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int CSR_ADDR_W      = 1;
   localparam logic [CSR_ADDR_W-1:0] REG_POINT_COUNT = 1'b0;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] ST_INTERIOR = 2'd0;
   localparam logic [1:0] ST_LOW      = 2'd1;
   localparam logic [1:0] ST_HIGH     = 2'd2;
   localparam logic [1:0] ST_ERROR    = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE, S_RD_ENDS, S_WAIT_ENDS, S_CHECK_ENDS, S_PROBE, S_WAIT_PROBE,
      S_DECIDE, S_RD_PAIR, S_WAIT_PAIR, S_MUL, S_DIV, S_FINISH, S_DONE
   } state_type;

   // Datapath commands from the controller.
   typedef struct packed {
      logic load;      // capture item, write table on load
      logic rd_ends;   // read entries 0 and n-1
      logic rd_mid;    // read entries mid and mid+1
      logic rd_pair;   // read y at found interval
      logic search_init;
      logic search_step;
      logic mul;
      logic div_start;
      logic div_step;
      logic finish;
      logic emit;
   } cmd_type;

   // Datapath status to the controller.
   typedef struct packed {
      logic is_query;
      logic ends_clamped;
      logic search_empty;  // lo > hi
      logic search_hit;
      logic div_last;
   } sts_type;
endpackage

// File: hdl/tli_ctrl.sv
// ----------------------------------------------------------------------------
// tli_ctrl
// Sequencer for load, end check, binary search, multiply and divide.
// ----------------------------------------------------------------------------
module tli_ctrl import tli_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:       if (start) state_in = S_RD_ENDS;
         S_RD_ENDS:    state_in = sts.is_query ? S_WAIT_ENDS : S_IDLE;
         S_WAIT_ENDS:  state_in = S_CHECK_ENDS;
         S_CHECK_ENDS: state_in = sts.ends_clamped ? S_DONE : S_PROBE;
         S_PROBE:      state_in = sts.search_empty ? S_DONE : S_WAIT_PROBE;
         S_WAIT_PROBE: state_in = S_DECIDE;
         S_DECIDE:     state_in = sts.search_hit ? S_RD_PAIR : S_PROBE;
         S_RD_PAIR:    state_in = S_WAIT_PAIR;
         S_WAIT_PAIR:  state_in = S_MUL;
         S_MUL:        state_in = S_DIV;
         S_DIV:        if (sts.div_last) state_in = S_FINISH;
         S_FINISH:     state_in = S_DONE;
         S_DONE:       state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE:       begin cmd.load = start; end
         S_RD_ENDS:    begin cmd.rd_ends = sts.is_query; end
         S_WAIT_ENDS:  begin end
         S_CHECK_ENDS: begin cmd.search_init = 1'b1; end
         S_PROBE:      begin cmd.rd_mid = 1'b1; end
         S_WAIT_PROBE: begin end
         S_DECIDE:     begin cmd.search_step = 1'b1; end
         S_RD_PAIR:    begin cmd.rd_pair = 1'b1; end
         S_WAIT_PAIR:  begin end
         S_MUL:        begin cmd.mul = 1'b1; cmd.div_start = 1'b1; end
         S_DIV:        begin cmd.div_step = 1'b1; end
         S_FINISH:     begin cmd.finish = 1'b1; end
         S_DONE:       begin cmd.emit = 1'b1; end
         default:      begin end
      endcase
   end
endmodule

// File: hdl/tli_datapath.sv
// ----------------------------------------------------------------------------
// tli_datapath
// Point tables, end compare, search bounds, multiplier and restoring divider.
// ----------------------------------------------------------------------------
module tli_datapath import tli_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [8:0]         point_count,
   input  logic               req_op,
   input  logic [7:0]         req_point_index,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_query_x,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_y_result,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_interval_index
);
   localparam int AW = (TABLE_DEPTH > 256) ? 9 : $clog2(TABLE_DEPTH);
   localparam int PW = 64;
   localparam int DC = 6;   // quotient bit counter width

   logic [31:0] x_mem [TABLE_DEPTH];
   logic [31:0] y_mem [TABLE_DEPTH];

   logic              op_ff;
   logic [31:0]       q_ff;
   logic [8:0]        n_ff;         // clamped count
   logic [31:0]       xa_ff, xb_ff, ya_ff, yb_ff;
   logic [AW-1:0]     ra_ff, rb_ff;
   logic signed [9:0] lo_ff, hi_ff;
   logic [8:0]        mid_ff;
   logic [8:0]        ivl_ff;
   logic signed [31:0] y0_ff;
   logic [63:0]       rem_ff, quo_ff;
   logic [32:0]       dxm_ff;
   logic [DC-1:0]     cnt_ff;
   logic              neg_ff;
   logic              valid_ff;
   logic signed [31:0] res_ff;
   logic [1:0]        status_ff;
   logic [7:0]        ivlo_ff;

   logic [8:0] n_c;
   always_comb begin
      n_c = point_count;
      if (n_c < 9'd2) n_c = 9'd2;
      if ({23'd0, n_c} > TABLE_DEPTH) n_c = 9'(TABLE_DEPTH);
   end

   // Table ports: one write and a two-entry read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.load && req_op == OP_LOAD && {24'd0, req_point_index} < TABLE_DEPTH) begin
         x_mem[AW'(req_point_index)] <= req_point_x;
         y_mem[AW'(req_point_index)] <= req_point_y;
      end
      xa_ff <= x_mem[ra_ff];
      xb_ff <= x_mem[rb_ff];
      ya_ff <= y_mem[ra_ff];
      yb_ff <= y_mem[rb_ff];
   end

   logic signed [32:0] qs, xas, xbs;
   assign qs  = {q_ff[31], q_ff};
   assign xas = {xa_ff[31], xa_ff};
   assign xbs = {xb_ff[31], xb_ff};

   assign sts.is_query     = op_ff;
   assign sts.ends_clamped = (qs <= xas) || (qs >= xbs);
   assign sts.search_empty = (lo_ff > hi_ff);
   assign sts.search_hit   = (lo_ff == hi_ff) || ((xas <= qs) && (qs < xbs));
   assign sts.div_last     = (cnt_ff == '0);

   logic signed [33:0] dx_c, dy_c, t_c;
   assign dx_c = 34'(signed'(xbs)) - 34'(signed'(xas));
   assign dy_c = {{2{yb_ff[31]}}, yb_ff} - {{2{ya_ff[31]}}, ya_ff};
   assign t_c  = 34'(signed'(qs)) - 34'(signed'(xas));

   logic [32:0] dym, tm;
   assign dym = dy_c[33] ? 33'(-dy_c) : 33'(dy_c);
   assign tm  = t_c[33]  ? 33'(-t_c)  : 33'(t_c);

   logic [64:0] trial;
   assign trial = {rem_ff[63:0], quo_ff[63]} - {32'd0, dxm_ff};

   logic signed [34:0] sum_c;
   logic [63:0] qlim;
   assign qlim  = (quo_ff > (64'd1 << 33)) ? (64'd1 << 33) : quo_ff;
   assign sum_c = neg_ff ? 35'(y0_ff) - 35'(qlim) : 35'(y0_ff) + 35'(qlim);

   logic signed [9:0] mid_s;
   assign mid_s = (lo_ff + hi_ff) >>> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit;
      end
      if (cmd.load) begin
         op_ff <= req_op; q_ff <= req_query_x;
         n_ff <= n_c;
      end
      if (cmd.rd_ends) begin
         ra_ff <= '0; rb_ff <= AW'(n_ff - 9'd1);
      end
      if (cmd.search_init) begin
         lo_ff <= '0; hi_ff <= 10'(n_ff) - 10'sd2;
         if (qs <= xas) begin
            res_ff <= ya_ff; status_ff <= ST_LOW; ivlo_ff <= '0;
         end else begin
            res_ff <= yb_ff; status_ff <= ST_HIGH; ivlo_ff <= 8'(n_ff - 9'd2);
         end
      end
      if (cmd.rd_mid) begin
         if (lo_ff > hi_ff) begin
            res_ff <= '0; status_ff <= ST_ERROR; ivlo_ff <= '0;
         end
         mid_ff <= 9'(mid_s);
         ra_ff <= AW'(mid_s); rb_ff <= AW'(mid_s + 10'sd1);
      end
      if (cmd.search_step) begin
         if (lo_ff == hi_ff) ivl_ff <= 9'(lo_ff);
         else ivl_ff <= mid_ff;
         if (qs < xas) hi_ff <= 10'(mid_ff) - 10'sd1;
         else lo_ff <= 10'(mid_ff) + 10'sd1;
      end
      if (cmd.rd_pair) begin
         ra_ff <= AW'(ivl_ff); rb_ff <= AW'(ivl_ff + 9'd1);
      end
      if (cmd.mul) begin
         y0_ff  <= ya_ff;
         quo_ff <= 64'(dym) * 64'(tm);
         dxm_ff <= dx_c[33] ? 33'(-dx_c) : 33'(dx_c);
         neg_ff <= (dy_c[33] != t_c[33]) != dx_c[33];
         if (dx_c == '0) begin
            status_ff <= ST_ERROR; res_ff <= '0;
         end else status_ff <= ST_INTERIOR;
         ivlo_ff <= 8'(ivl_ff);
      end
      if (cmd.div_start) begin
         rem_ff <= '0;
         cnt_ff <= DC'(PW - 1);
      end
      if (cmd.div_step) begin
         if (!trial[64]) begin
            rem_ff <= trial[63:0]; quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[62:0], quo_ff[63]}; quo_ff <= {quo_ff[62:0], 1'b0};
         end
         cnt_ff <= cnt_ff - DC'(1);
      end
      if (cmd.finish && status_ff == ST_INTERIOR) begin
         if (sum_c > 35'sh7FFFFFFF) res_ff <= 32'sh7FFFFFFF;
         else if (sum_c < -35'sh80000000) res_ff <= 32'sh80000000;
         else res_ff <= 32'(sum_c);
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_y_result       = res_ff;
   assign rsp_status         = status_ff;
   assign rsp_interval_index = ivlo_ff;
endmodule

// File: hdl/table_linear_interpolator.sv
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise linear interpolation over a loaded Q16.16 table.
// ----------------------------------------------------------------------------
// A word is accepted when req_start is high and req_busy is low. A word with
// op 0 writes one table point and yields no result; the block is busy for
// one cycle. A word with op 1 queries the table and yields one result word,
// shown on the rsp_ ports for one cycle while rsp_valid is high. The
// receiver cannot stall, so nothing is held back.
// A query that is clamped to an end skips the search; else it runs a binary
// search (up to 8 probes for 256 points), then a multiply and a bit-serial
// restoring division of the 64-bit product.
// The divider retires one quotient bit per cycle. Reset clears the
// controller and sets point_count to 2; the table is not cleared and must be
// written before it is read. point_count is written through the csr_ port at
// byte address 0. Write it only while the block is idle; the block does not check.
module table_linear_interpolator import tli_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   output logic               req_busy,
   input  logic               req_op,
   input  logic [7:0]         req_point_index,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_query_x,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_y_result,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_interval_index,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_ADDR_W+1:0] csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   cmd_type cmd;
   sts_type sts;
   logic [8:0] count_ff;

   // Register file: a single count register at address zero.
   always_ff @(posedge clock) begin
      if (reset) count_ff <= 9'd2;
      else if (csr_psel && csr_penable && csr_pwrite &&
               csr_paddr[CSR_ADDR_W+1:2] == REG_POINT_COUNT)
         count_ff <= csr_pwdata[8:0];
   end
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W+1:2] == REG_POINT_COUNT) ?
                       {23'd0, count_ff} : 32'd0;

   tli_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(req_start), .busy(req_busy),
      .sts(sts), .cmd(cmd)
   );

   tli_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .point_count(count_ff), .req_op(req_op), .req_point_index(req_point_index),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_query_x(req_query_x), .rsp_valid(rsp_valid),
      .rsp_y_result(rsp_y_result), .rsp_status(rsp_status),
      .rsp_interval_index(rsp_interval_index)
   );
endmodule

// File: hdl/tli_checker.sv
// ----------------------------------------------------------------------------
// tli_checker
// Port-level checks of the table interpolator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tli_checker import tli_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_start,
   input logic       req_busy,
   input logic       req_op,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_interval_index
);
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_start && !req_busy, req_busy, "no busy")
   `ASSERT_NEXT(a_valid_pulse, clock, reset, rsp_valid, !rsp_valid, "valid held")
   `ASSERT_IMPL(a_valid_busy, clock, reset, rsp_valid, req_busy || $past(req_busy), "idle rsp")
   `ASSERT_IMPL(a_low_index, clock, reset, rsp_valid && rsp_status == ST_LOW,
      rsp_interval_index == 8'd0, "low clamp index")
   `ASSERT_NEXT(a_load_quiet, clock, reset, req_start && !req_busy && req_op == OP_LOAD,
      !rsp_valid, "load gave result")
endmodule

bind table_linear_interpolator tli_checker u_tli_checker (
   .clock(clock), .reset(reset), .req_start(req_start), .req_busy(req_busy),
   .req_op(req_op), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
   .rsp_interval_index(rsp_interval_index)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Table interpolator testbench
// Loads interpolation tables through the command port, sets the point count
// through the CSR port and fires queries at them. A behavioral model inside
// the bench predicts every result word, and a monitor compares each result
// with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   import tli_pkg::*;

   localparam int DEPTH       = 256;
   localparam int CYCLE_LIMIT = 1500000;
   // Slack after the last result, longer than the longest query takes.
   localparam int DRAIN_CYCLES = 150;

   typedef struct {
      logic signed [31:0] y;
      logic [1:0]         status;
      logic [7:0]         interval;
   } interp_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_start = 1'b0;
   logic               req_busy;
   logic               req_op = OP_LOAD;
   logic [7:0]         req_point_index = '0;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_query_x = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_y_result;
   logic [1:0]         rsp_status;
   logic [7:0]         rsp_interval_index;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [CSR_ADDR_W+1:0] csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   // Bench copy of the table and of the point count register.
   logic signed [31:0] table_x [DEPTH];
   logic signed [31:0] table_y [DEPTH];
   logic [8:0]         point_count_reg = 9'd2;

   interp_result_type  pending_results[$];
   int                 mismatch_count = 0;
   int                 cycle_count = 0;
   // Chance, in percent, that the sender lengthens its idle gap once more.
   int                 sender_idle_pct = 0;

   table_linear_interpolator DUT (
      .clock(clock), .reset(reset),
      .req_start(req_start), .req_busy(req_busy), .req_op(req_op),
      .req_point_index(req_point_index), .req_point_x(req_point_x),
      .req_point_y(req_point_y), .req_query_x(req_query_x),
      .rsp_valid(rsp_valid), .rsp_y_result(rsp_y_result),
      .rsp_status(rsp_status), .rsp_interval_index(rsp_interval_index),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The run is bounded; a hang anywhere shows up as a failure here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // Interpolation as the block defines it: clamp at the ends, binary search
   // over the first n points, then y0 + dy*(q-x0)/dx with the correction
   // truncated toward zero, limited to 2^33 and the sum saturated.
   function automatic interp_result_type interpolate(input logic signed [31:0] qx);
      interp_result_type r;
      int             n, lo, hi, mid, hit;
      longint         q, x0, x1, y0, y1, dx, dy, t, sum;
      longint unsigned prod, quo, mdx;
      bit             neg;
      n = point_count_reg;
      if (n < 2) n = 2;
      if (n > DEPTH) n = DEPTH;
      q = qx;
      r.y = '0;
      r.status = ST_INTERIOR;
      r.interval = '0;
      if (q <= longint'(table_x[0])) begin
         r.y = table_y[0];
         r.status = ST_LOW;
      end else if (q >= longint'(table_x[n-1])) begin
         r.y = table_y[n-1];
         r.status = ST_HIGH;
         r.interval = 8'(n - 2);
      end else begin
         lo = 0;
         hi = n - 2;
         hit = -1;
         while (lo <= hi && hit < 0) begin
            if (lo == hi) begin
               hit = lo;
            end else begin
               mid = (lo + hi) / 2;
               if (longint'(table_x[mid]) <= q && q < longint'(table_x[mid+1]))
                  hit = mid;
               else if (q < longint'(table_x[mid]))
                  hi = mid - 1;
               else
                  lo = mid + 1;
            end
         end
         if (hit < 0) begin
            r.status = ST_ERROR;
         end else begin
            r.interval = 8'(hit);
            x0 = table_x[hit];
            x1 = table_x[hit+1];
            y0 = table_y[hit];
            y1 = table_y[hit+1];
            dx = x1 - x0;
            if (dx == 0) begin
               r.status = ST_ERROR;
            end else begin
               dy = y1 - y0;
               t = q - x0;
               mdx = (dx < 0) ? -dx : dx;
               prod = longint'((dy < 0) ? -dy : dy) * longint'((t < 0) ? -t : t);
               quo = prod / mdx;
               if (quo > 64'd1 << 33) quo = 64'd1 << 33;
               neg = ((dy < 0) != (t < 0)) != (dx < 0);
               sum = neg ? y0 - longint'(quo) : y0 + longint'(quo);
               if (sum > 64'sd2147483647) sum = 64'sd2147483647;
               if (sum < -64'sd2147483648) sum = -64'sd2147483648;
               r.y = sum[31:0];
            end
         end
      end
      return r;
   endfunction

   // Result monitor: every strobed word must match the oldest prediction.
   // The result ports are sampled mid-cycle, where they are settled.
   always @(negedge clock) begin
      interp_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result word: y=%h status=%0d interval=%0d",
                        rsp_y_result, rsp_status, rsp_interval_index);
         end else begin
            want = pending_results.pop_front();
            if (rsp_y_result !== want.y || rsp_status !== want.status ||
                rsp_interval_index !== want.interval) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Result mismatch: expected y=%h status=%0d interval=%0d, %s",
                           want.y, want.status, want.interval,
                           $sformatf("got y=%h status=%0d interval=%0d",
                                     rsp_y_result, rsp_status, rsp_interval_index));
            end
         end
      end
   end

   // Sends one command word and holds it until the block takes it. Busy is
   // looked at mid-cycle, so the edge that follows a low busy is the
   // accepting edge. The table copy is updated, or the result predicted, at
   // that edge, so the predictions stay in the block's own order. Start
   // stays high when the next word follows at once.
   task automatic send_word(input logic op, input logic [7:0] index,
                            input logic signed [31:0] px, input logic signed [31:0] py,
                            input logic signed [31:0] qx);
      int gap;
      bit was_idle;
      req_start <= 1'b1;
      req_op <= op;
      req_point_index <= index;
      req_point_x <= px;
      req_point_y <= py;
      req_query_x <= qx;
      do begin
         @(negedge clock);
         was_idle = !req_busy;
         @(posedge clock);
      end while (!was_idle);
      if (op == OP_LOAD) begin
         table_x[index] = px;
         table_y[index] = py;
      end else begin
         pending_results = {pending_results, interpolate(qx)};
      end
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req_start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load_point(input int index, input logic signed [31:0] px,
                             input logic signed [31:0] py);
      send_word(OP_LOAD, 8'(index), px, py, $urandom);
   endtask

   task automatic query(input logic signed [31:0] qx);
      send_word(OP_QUERY, 8'($urandom), $urandom, $urandom, qx);
   endtask

   // The block must be idle for a register write: lower start, let every
   // predicted word arrive, then give a trailing load time to finish.
   task automatic wait_idle();
      req_start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_point_count(input logic [8:0] value);
      wait_idle();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {REG_POINT_COUNT, 2'b00};
      csr_pwdata <= {$urandom_range(0, 1) ? 23'h7fffff : 23'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      point_count_reg = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Writes entries 0..m-1. Kind 0 is strictly ascending, kind 1 ascending
   // with repeated x values, kind 2 unordered noise.
   task automatic rebuild_table(input int m, input int kind);
      longint x;
      int     step_max;
      step_max = (m > 16) ? 4000000 : 60000000;
      x = longint'($signed($urandom_range(0, 2000000000))) - 1000000000;
      for (int i = 0; i < m; i++) begin
         if (kind == 2)
            load_point(i, $urandom, $urandom);
         else
            load_point(i, 32'(x), $urandom);
         if (kind == 1 && $urandom_range(2) == 0)
            x = x;
         else
            x += $urandom_range(1, step_max);
      end
   endtask

   // Picks an abscissa that reaches the interesting parts of the table in use.
   function automatic logic signed [31:0] pick_query();
      int     n, i;
      longint lo_x, hi_x;
      n = point_count_reg;
      if (n < 2) n = 2;
      if (n > DEPTH) n = DEPTH;
      i = $urandom_range(0, n - 2);
      lo_x = table_x[i];
      hi_x = table_x[i+1];
      case ($urandom_range(9))
         0: return $urandom;
         1: return table_x[i];
         2: return table_x[$urandom_range(0, 1) ? 0 : n - 1] + $signed($urandom_range(0, 2)) - 1;
         3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: begin
            if (hi_x > lo_x)
               return 32'(lo_x + longint'($urandom) % (hi_x - lo_x));
            return table_x[i];
         end
      endcase
   endfunction

   // Fills the whole table once, so no query can ever read an unwritten
   // entry, and sweeps every load index.
   task automatic test_table_fill();
      rebuild_table(DEPTH, 0);
   endtask

   // Ends of the fields, both clamps, exact table points, the full table
   // size and the extreme x and y values at the first and last entries.
   task automatic test_directed();
      query(32'sh80000000);
      query(32'sh7fffffff);
      query(table_x[0]);
      query(table_x[1]);
      query(table_x[0] + 1);
      query(table_x[1] - 1);
      write_point_count(9'd256);
      query(table_x[255]);
      query(table_x[255] - 1);
      query(table_x[128]);
      query(table_x[128] + 1);
      query(32'sh0);
      load_point(0, 32'sh80000000, 32'sh7fffffff);
      load_point(255, 32'sh7fffffff, 32'sh80000000);
      query(32'sh80000000);
      query(32'sh80000001);
      query(32'sh7ffffffe);
      query(32'sh7fffffff);
      // Counts outside the legal range act as the nearest legal count.
      write_point_count(9'd0);
      query(pick_query());
      query(table_x[0] + 1);
      write_point_count(9'd511);
      query(pick_query());
      query(32'sh7ffffffe);
   endtask

   // Rounds of random traffic: each round sets a count, often rebuilds the
   // start of the table, then sends mostly queries with some loads as noise.
   // The count write between rounds also lets the block drain fully.
   task automatic test_random(input int idle_pct, input int rounds);
      int n, kind;
      sender_idle_pct = idle_pct;
      for (int r = 0; r < rounds; r++) begin
         case ($urandom_range(5))
            0: n = 2;
            1: n = 256;
            2: n = $urandom_range(0, 511);
            default: n = $urandom_range(3, 16);
         endcase
         write_point_count(9'(n));
         kind = $urandom_range(9);
         if (n <= 16 && kind < 8)
            rebuild_table((n < 2) ? 2 : n, (kind < 5) ? 0 : (kind < 7) ? 1 : 2);
         for (int k = 0; k < 20; k++) begin
            if ($urandom_range(9) == 0)
               load_point($urandom_range(0, 255), $urandom, $urandom);
            else
               query(pick_query());
         end
      end
      sender_idle_pct = 0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_fill();
      test_directed();
      test_random(24, 4);
      test_random(87, 4);
      test_random(0, 4);
      wait_idle();
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
